// ===== hdl/csp_pkg.sv =====
// package: record layout and status codes of the call stack profiler
`timescale 1ns / 1ps
`default_nettype none
package csp_pkg;

  localparam int unsigned TimeW  = 64;
  localparam int unsigned CountW = 32;
  localparam int unsigned DepthW = 7;
  localparam int unsigned IndexW = 6;
  localparam logic [DepthW-1:0] DepthMax = '1;
  localparam logic [TimeW-1:0]  TimeOnes = '1;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_EMPTY    = 3'd1,
    STAT_MISMATCH = 3'd2,
    STAT_TBL_FULL = 3'd3,
    STAT_STK_FULL = 3'd4
  } status_t;

  // one function record as held in the record memory
  typedef struct packed {
    logic [CountW-1:0] calls;
    logic [TimeW-1:0]  total;
    logic [TimeW-1:0]  self_acc;
    logic [TimeW-1:0]  min_el;
    logic [TimeW-1:0]  max_el;
    logic [TimeW-1:0]  min_sf;
    logic [TimeW-1:0]  max_sf;
    logic [TimeW-1:0]  pend;
    logic [TimeW-1:0]  last;
    logic [DepthW-1:0] depth;
  } rec_t;

endpackage
`default_nettype wire

// ===== hdl/call_stack_profiler.sv =====
// top level: call stack profiler with record, symbol and stack memories
//
// channel  dir  handshake               payload
// in_      in   in_tvalid/in_tready     tuser: operation; tdata: func_addr, timestamp
// out_     out  out_tvalid/out_tready   tuser: status; tdata: record fields
//
// one event at a time; an enter scans the symbol memory entry by entry (S_SRD read,
// S_SCMP compare), adds a new entry if none matches, pushes a frame, updates the caller
// record (S_PRD, S_PMOD) unless the stack is empty, then its own record (S_ERD, S_EMOD)
// an exit runs S_XRD to S_XUPD, then S_XPRD to S_XPW when a caller frame is below it
// each memory has one read port and one write port
// reset clears the stack pointer and fill count; the memories need no clearing
// a result waiting on out_tready stalls only the final step, the next request is taken
`timescale 1ns / 1ps
`default_nettype none
module call_stack_profiler
  import csp_pkg::*;
#(
  parameter int unsigned TABLE_ENTRIES = 64,
  parameter int unsigned STACK_DEPTH   = 64
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,   // func_addr[63:0], timestamp[127:64]
  input  wire logic [0:0]   in_tuser,   // operation[0]
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [431:0]      out_tdata,  // entry_index[5:0], call_count[37:6],
                                        // total_elapsed[101:38], self_elapsed[165:102],
                                        // min_elapsed[229:166], max_elapsed[293:230],
                                        // min_self[357:294], max_self[421:358],
                                        // recursion_depth[428:422], zeros[431:429]
  output logic [2:0]        out_tuser   // status[2:0]
);

  localparam int unsigned TW  = $clog2(TABLE_ENTRIES);
  localparam int unsigned UW  = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned SW  = $clog2(STACK_DEPTH);
  localparam int unsigned SPW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_SRD, S_SCMP, S_PUSH, S_PRD, S_PMOD, S_ERD, S_EMOD,
    S_XRD, S_XTOP, S_XCHK, S_XUPD, S_XPRD, S_XPRQ, S_XPW, S_OUT
  } state_t;

  state_t state_r;
  logic [SPW-1:0] sp_r;
  logic [UW-1:0]  used_r;
  logic [UW-1:0]  idx_r;
  logic [TW-1:0]  slot_r, par_r;
  logic [TimeW-1:0] addr_r, t_r, stime_r, pend_r, delta_r;
  rec_t    rec_r, res_r;
  status_t stat_r;
  logic         out_valid_r;
  logic [431:0] out_data_r;
  logic [2:0]   out_user_r;

  // memories
  logic [TimeW-1:0] sym_mem [TABLE_ENTRIES];
  rec_t             rec_mem [TABLE_ENTRIES];
  logic [TW-1:0]    stk_slot_mem [STACK_DEPTH];
  logic [TimeW-1:0] stk_time_mem [STACK_DEPTH];

  logic          sym_we, rec_we, stk_we;
  logic [TW-1:0] sym_wa, sym_ra, rec_wa, rec_ra;
  logic [SW-1:0] stk_wa, stk_ra;
  rec_t          rec_wd, rec_q;
  logic [TimeW-1:0] sym_q, stk_time_q;
  logic [TW-1:0]    stk_slot_q;

  always_ff @(posedge clk) begin
    if (sym_we) sym_mem[sym_wa] <= addr_r;
    sym_q <= sym_mem[sym_ra];
  end

  always_ff @(posedge clk) begin
    if (rec_we) rec_mem[rec_wa] <= rec_wd;
    rec_q <= rec_mem[rec_ra];
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_slot_mem[stk_wa] <= slot_r;
      stk_time_mem[stk_wa] <= t_r;
    end
    stk_slot_q <= stk_slot_mem[stk_ra];
    stk_time_q <= stk_time_mem[stk_ra];
  end

  // record update arithmetic
  rec_t rec_init, rec_par_en, rec_ent, rec_ext, rec_par_ex;
  logic [SPW-1:0] sp_m1, sp_m2;

  always_comb begin
    sp_m1 = sp_r - SPW'(1);
    sp_m2 = sp_r - SPW'(2);

    rec_init        = '0;
    rec_init.min_el = TimeOnes;
    rec_init.min_sf = TimeOnes;

    rec_par_en      = rec_q;
    rec_par_en.pend = rec_q.pend + (t_r - rec_q.last);

    rec_ent = rec_q;
    if (rec_q.depth == '0) rec_ent.pend = '0;
    if (rec_q.depth != DepthMax) rec_ent.depth = rec_q.depth + DepthW'(1);
    if (rec_q.calls != '1) rec_ent.calls = rec_q.calls + CountW'(1);
    rec_ent.last = t_r;

    rec_ext      = rec_r;
    rec_ext.pend = pend_r;
    if (rec_r.depth <= DepthW'(1)) begin
      rec_ext.self_acc = rec_r.self_acc + pend_r;
      rec_ext.total    = rec_r.total + delta_r;
    end
    if (pend_r > rec_r.max_sf)  rec_ext.max_sf = pend_r;
    if (pend_r < rec_r.min_sf)  rec_ext.min_sf = pend_r;
    if (delta_r > rec_r.max_el) rec_ext.max_el = delta_r;
    if (delta_r < rec_r.min_el) rec_ext.min_el = delta_r;
    if (rec_r.depth != '0) rec_ext.depth = rec_r.depth - DepthW'(1);

    rec_par_ex      = rec_q;
    rec_par_ex.last = t_r;
  end

  // memory port control
  always_comb begin
    sym_we = 1'b0;
    sym_wa = used_r[TW-1:0];
    sym_ra = idx_r[TW-1:0];
    rec_we = 1'b0;
    rec_wa = slot_r;
    rec_wd = rec_ent;
    rec_ra = slot_r;
    stk_we = 1'b0;
    stk_wa = sp_r[SW-1:0];
    stk_ra = sp_m1[SW-1:0];
    case (state_r)
      S_SRD: begin
        if (idx_r == used_r && used_r != UW'(TABLE_ENTRIES)
            && sp_r != SPW'(STACK_DEPTH)) begin
          sym_we = 1'b1;
          rec_we = 1'b1;
          rec_wa = used_r[TW-1:0];
          rec_wd = rec_init;
        end
      end
      S_PUSH: stk_we = 1'b1;
      S_PRD:  rec_ra = stk_slot_q;
      S_PMOD: begin
        rec_we = 1'b1;
        rec_wa = par_r;
        rec_wd = rec_par_en;
      end
      S_EMOD: rec_we = 1'b1;
      S_XTOP: begin
        sym_ra = stk_slot_q;
        rec_ra = stk_slot_q;
      end
      S_XUPD: begin
        rec_we = 1'b1;
        rec_wd = rec_ext;
      end
      S_XPRD: stk_ra = sp_m2[SW-1:0];
      S_XPRQ: rec_ra = stk_slot_q;
      S_XPW: begin
        rec_we = 1'b1;
        rec_wa = par_r;
        rec_wd = rec_par_ex;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      sp_r        <= '0;
      used_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // in S_OUT the output register is reloaded below instead
      if (out_valid_r && out_tready && state_r != S_OUT) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            addr_r <= in_tdata[63:0];
            t_r    <= in_tdata[127:64];
            idx_r  <= '0;
            stat_r <= STAT_OK;
            if (!in_tuser[0]) begin
              state_r <= S_SRD;
            end else if (sp_r == '0) begin
              stat_r  <= STAT_EMPTY;
              state_r <= S_OUT;
            end else begin
              state_r <= S_XRD;
            end
          end
        end
        S_SRD: begin
          if (idx_r != used_r) begin
            state_r <= S_SCMP;
          end else if (used_r == UW'(TABLE_ENTRIES)) begin
            stat_r  <= STAT_TBL_FULL;
            state_r <= S_OUT;
          end else if (sp_r == SPW'(STACK_DEPTH)) begin
            stat_r  <= STAT_STK_FULL;
            state_r <= S_OUT;
          end else begin
            slot_r  <= used_r[TW-1:0];
            used_r  <= used_r + UW'(1);
            state_r <= S_PUSH;
          end
        end
        S_SCMP: begin
          if (sym_q != addr_r) begin
            idx_r   <= idx_r + UW'(1);
            state_r <= S_SRD;
          end else if (sp_r == SPW'(STACK_DEPTH)) begin
            stat_r  <= STAT_STK_FULL;
            state_r <= S_OUT;
          end else begin
            slot_r  <= idx_r[TW-1:0];
            state_r <= S_PUSH;
          end
        end
        S_PUSH: begin
          sp_r    <= sp_r + SPW'(1);
          state_r <= (sp_r != '0) ? S_PRD : S_ERD;
        end
        S_PRD: begin
          par_r   <= stk_slot_q;
          state_r <= S_PMOD;
        end
        S_PMOD: state_r <= S_ERD;
        S_ERD:  state_r <= S_EMOD;
        S_EMOD: begin
          res_r   <= rec_ent;
          state_r <= S_OUT;
        end
        S_XRD: state_r <= S_XTOP;
        S_XTOP: begin
          slot_r  <= stk_slot_q;
          stime_r <= stk_time_q;
          state_r <= S_XCHK;
        end
        S_XCHK: begin
          if (sym_q != addr_r) begin
            stat_r  <= STAT_MISMATCH;
            state_r <= S_OUT;
          end else begin
            rec_r   <= rec_q;
            pend_r  <= rec_q.pend + (t_r - rec_q.last);
            delta_r <= t_r - stime_r;
            state_r <= S_XUPD;
          end
        end
        S_XUPD: begin
          res_r <= rec_ext;
          if (sp_r > SPW'(1)) begin
            state_r <= S_XPRD;
          end else begin
            sp_r    <= sp_m1;
            state_r <= S_OUT;
          end
        end
        S_XPRD: state_r <= S_XPRQ;
        S_XPRQ: begin
          par_r   <= stk_slot_q;
          state_r <= S_XPW;
        end
        S_XPW: begin
          sp_r    <= sp_m1;
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_user_r  <= stat_r;
            if (stat_r == STAT_OK) begin
              out_data_r <= {3'b000, res_r.depth, res_r.max_sf, res_r.min_sf,
                             res_r.max_el, res_r.min_el, res_r.self_acc,
                             res_r.total, res_r.calls, IndexW'(slot_r)};
            end else begin
              out_data_r <= '0;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SPW'(STACK_DEPTH)) else $error("stack pointer beyond depth");

  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= UW'(TABLE_ENTRIES)) else $error("fill count beyond table");

  a_used_grows: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> used_r >= $past(used_r)) else $error("fill count shrank");

  a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_user_r != STAT_OK |-> out_data_r == '0)
    else $error("flagged result carries data");

endmodule
`default_nettype wire
